// ----- hdl/cctip_pkg.sv -----
// Shared types and constants of the cycle counter time interpolator.
`default_nettype none
package cctip_pkg;

    localparam int CNT_W    = 32;
    localparam int OFF_W    = 14;
    localparam int WIDE_W   = 64;
    localparam int S_DATA_W = 64;
    localparam int M_DATA_W = 48;

    // Item kinds carried in s_tuser.
    localparam logic OP_TICK  = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    // Operand selection of the shared divider.
    localparam logic DIV_SEL_TICK  = 1'b0;
    localparam logic DIV_SEL_RECIP = 1'b1;

    typedef struct packed {
        logic capture;
        logic tick_upd;
        logic seen_load;
        logic div_start;
        logic div_sel;
        logic recip_ones;
        logic recip_load;
        logic mul_load;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic op;
        logic need_recip;
        logic div_done;
        logic quo_zero;
        logic out_free;
    } sts_t;

endpackage
`default_nettype wire

// ----- hdl/cctip_div.sv -----
// Restoring 64-by-64 bit divider that produces one quotient bit per cycle.
`default_nettype none
module cctip_div (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          start,
    input  wire logic [cctip_pkg::WIDE_W-1:0]  dividend,
    input  wire logic [cctip_pkg::WIDE_W-1:0]  divisor,
    output logic                               done,
    output logic [cctip_pkg::WIDE_W-1:0]       quotient
);

    localparam int W     = cctip_pkg::WIDE_W;
    localparam int CNT_B = $clog2(W);

    logic [W-1:0]     rem_reg, rem_next;
    logic [W-1:0]     quo_reg, quo_next;
    logic [W-1:0]     dvs_reg;
    logic [CNT_B-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;
    logic [W:0]       shifted;
    logic [W+1:0]     diff;

    always_comb begin
        shifted = {rem_reg, quo_reg[W-1]};
        diff    = {1'b0, shifted} - {2'b00, dvs_reg};
        if (!diff[W+1]) begin
            rem_next = diff[W-1:0];
            quo_next = {quo_reg[W-2:0], 1'b1};
        end else begin
            rem_next = shifted[W-1:0];
            quo_next = {quo_reg[W-2:0], 1'b0};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= busy_reg && (cnt_reg == CNT_B'(W - 1));
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_B'(W - 1)) begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg <= '0;
            quo_reg <= dividend;
            dvs_reg <= divisor;
        end else if (busy_reg) begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule
`default_nettype wire

// ----- hdl/cctip_dp.sv -----
// Datapath: count state, reciprocal cache, divider, multiplier and output register.
`default_nettype none
module cctip_dp #(
    parameter int USECS_PER_TICK = 10000
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire cctip_pkg::cmd_t                 cmd,
    output cctip_pkg::sts_t                      sts,
    input  wire logic                            in_tuser,
    input  wire logic [cctip_pkg::S_DATA_W-1:0]  in_tdata,
    output logic [cctip_pkg::M_DATA_W-1:0]       out_tdata,
    output logic                                 out_tvalid,
    input  wire logic                            out_tready,
    input  wire logic                            cfg_wr_en,
    input  wire logic [cctip_pkg::CNT_W-1:0]     cfg_wr_data
);

    localparam int CW = cctip_pkg::CNT_W;
    localparam int WW = cctip_pkg::WIDE_W;
    localparam int OW = cctip_pkg::OFF_W;
    localparam logic [WW-1:0] RECIP_NUM  = WW'(USECS_PER_TICK) << CW;
    localparam logic [CW-1:0] OFFSET_MAX = CW'(USECS_PER_TICK - 1);

    logic [CW-1:0] cfg_reg;
    logic          op_reg;
    logic [CW-1:0] count_reg;
    logic [CW-1:0] tick_reg;
    logic [CW-1:0] wrap_reg;
    logic [CW-1:0] last_reg;
    logic [CW-1:0] seen_reg;
    logic [CW-1:0] recip_reg;
    logic [WW-1:0] prod_reg;
    logic [cctip_pkg::M_DATA_W-1:0] out_data_reg;
    logic          out_valid_reg;

    logic [WW-1:0] div_dividend;
    logic [WW-1:0] div_divisor;
    logic [WW-1:0] div_quo;
    logic          div_done;
    logic [CW-1:0] delta;
    logic [CW-1:0] prod_hi;
    logic [CW-1:0] offset_sat;
    logic [CW-1:0] compare;
    logic          out_free;

    always_comb begin
        if (cmd.div_sel == cctip_pkg::DIV_SEL_TICK) begin
            div_dividend = {wrap_reg, last_reg};
            div_divisor  = {{(WW - CW){1'b0}}, tick_reg};
        end else begin
            div_dividend = RECIP_NUM;
            div_divisor  = div_quo;
        end
    end

    cctip_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_quo)
    );

    assign delta      = count_reg - last_reg;
    assign prod_hi    = prod_reg[WW-1:CW];
    assign offset_sat = (prod_hi > OFFSET_MAX) ? OFFSET_MAX : prod_hi;
    assign compare    = count_reg + cfg_reg;
    assign out_free   = !out_valid_reg || out_tready;

    always_comb begin
        sts.op         = op_reg;
        sts.need_recip = (tick_reg != '0) && (tick_reg != seen_reg);
        sts.div_done   = div_done;
        sts.quo_zero   = (div_quo == '0);
        sts.out_free   = out_free;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg       <= CW'(1000000);
            wrap_reg      <= '0;
            last_reg      <= '0;
            seen_reg      <= '0;
            recip_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                cfg_reg <= cfg_wr_data;
            end
            if (cmd.tick_upd) begin
                // A tick number of zero restarts the extended count.
                if (tick_reg == '0) begin
                    wrap_reg <= '0;
                    last_reg <= '0;
                end else begin
                    if (count_reg < last_reg) begin
                        wrap_reg <= wrap_reg + 1'b1;
                    end
                    last_reg <= count_reg;
                end
            end
            if (cmd.seen_load) begin
                seen_reg <= tick_reg;
            end
            if (cmd.recip_ones) begin
                recip_reg <= '1;
            end else if (cmd.recip_load) begin
                recip_reg <= div_quo[CW-1:0];
            end
            if (cmd.out_load) begin
                out_valid_reg <= 1'b1;
            end else if (out_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            op_reg    <= in_tuser;
            count_reg <= in_tdata[CW-1:0];
            tick_reg  <= in_tdata[2*CW-1:CW];
        end
        if (cmd.mul_load) begin
            prod_reg <= WW'(delta) * WW'(recip_reg);
        end
        if (cmd.out_load) begin
            if (op_reg == cctip_pkg::OP_TICK) begin
                out_data_reg <= {{(cctip_pkg::M_DATA_W - CW){1'b0}}, compare};
            end else begin
                out_data_reg <= {{(cctip_pkg::M_DATA_W - CW - OW){1'b0}},
                                 offset_sat[OW-1:0], {CW{1'b0}}};
            end
        end
    end

    assign out_tdata  = out_data_reg;
    assign out_tvalid = out_valid_reg;

endmodule
`default_nettype wire

// ----- hdl/cctip_ctrl.sv -----
// Controller state machine that sequences tick updates, divisions and queries.
`default_nettype none
module cctip_ctrl (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_tvalid,
    output logic                   s_tready,
    input  wire cctip_pkg::sts_t   sts,
    output cctip_pkg::cmd_t        cmd
);

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_CHECK = 7'b0000010,
        S_TICK  = 7'b0000100,
        S_DIV1  = 7'b0001000,
        S_DIV2  = 7'b0010000,
        S_MUL   = 7'b0100000,
        S_OUT   = 7'b1000000
    } state_t;

    state_t state_reg, state_next;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        unique case (state_reg)
            S_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.capture = 1'b1;
                    state_next  = S_CHECK;
                end
            end
            S_CHECK: begin
                if (sts.op == cctip_pkg::OP_TICK) begin
                    state_next = S_TICK;
                end else if (sts.need_recip) begin
                    cmd.seen_load = 1'b1;
                    cmd.div_start = 1'b1;
                    cmd.div_sel   = cctip_pkg::DIV_SEL_TICK;
                    state_next    = S_DIV1;
                end else begin
                    state_next = S_MUL;
                end
            end
            S_TICK: begin
                cmd.tick_upd = 1'b1;
                state_next   = S_OUT;
            end
            S_DIV1: begin
                cmd.div_sel = cctip_pkg::DIV_SEL_TICK;
                if (sts.div_done) begin
                    // Fewer cycles counted than ticks leaves no usable rate.
                    if (sts.quo_zero) begin
                        cmd.recip_ones = 1'b1;
                        state_next     = S_MUL;
                    end else begin
                        cmd.div_start = 1'b1;
                        cmd.div_sel   = cctip_pkg::DIV_SEL_RECIP;
                        state_next    = S_DIV2;
                    end
                end
            end
            S_DIV2: begin
                cmd.div_sel = cctip_pkg::DIV_SEL_RECIP;
                if (sts.div_done) begin
                    cmd.recip_load = 1'b1;
                    state_next     = S_MUL;
                end
            end
            S_MUL: begin
                cmd.mul_load = 1'b1;
                state_next   = S_OUT;
            end
            S_OUT: begin
                if (sts.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule
`default_nettype wire

// ----- hdl/cycle_counter_time_interpolator_unit.sv -----
// Top level of the cycle counter time interpolator.
`default_nettype none
// Extends a free-running 32-bit cycle counter to a 64-bit count and reports
// the microseconds elapsed since the last tick. An item with s_tuser low is a
// tick: it updates the wrap count and the stored count and returns the next
// compare value (count plus cycles_per_tick). An item with s_tuser high is a
// query: it returns the offset in microseconds, saturated just below one
// tick. One item is worked on at a time. A tick goes through the check, tick
// and output states to the result register, and a query whose tick number is
// zero or unchanged through the check, multiply and output states. A query
// with a new nonzero tick number refreshes the cached reciprocal through two
// passes of a shared restoring divider that yields one quotient bit per
// cycle (only one pass when the first quotient is zero). The result register
// lets the next item be taken while a result still waits on m_tready.
module cycle_counter_time_interpolator_unit #(
    parameter int USECS_PER_TICK = 10000
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    // Bits from 0: cycle_count[31:0], tick_number[63:32].
    input  wire logic [cctip_pkg::S_DATA_W-1:0]  s_tdata,
    // Bits from 0: op[0].
    input  wire logic                            s_tuser,
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    // Bits from 0: compare_value[31:0], offset_us[45:32], zero[47:46].
    output logic [cctip_pkg::M_DATA_W-1:0]       m_tdata,
    input  wire logic                            cfg_wr_en,
    input  wire logic [cctip_pkg::CNT_W-1:0]     cfg_wr_data
);

    cctip_pkg::cmd_t cmd;
    cctip_pkg::sts_t sts;

    cctip_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    cctip_dp #(
        .USECS_PER_TICK (USECS_PER_TICK)
    ) u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (cmd),
        .sts         (sts),
        .in_tuser    (s_tuser),
        .in_tdata    (s_tdata),
        .out_tdata   (m_tdata),
        .out_tvalid  (m_tvalid),
        .out_tready  (m_tready),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

`ifndef SYNTHESIS
    // Only one item is in flight, so an accepted item closes the input.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input accepted while an item is in flight");

    // The result register is loaded only when it is empty or being drained.
    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> (!m_tvalid || m_tready))
        else $error("result overwritten before it was taken");

    // A loaded result is offered on the next cycle.
    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |=> m_tvalid)
        else $error("loaded result not presented");
`endif

endmodule
`default_nettype wire
